FILE: hdl/agt6_pkg.sv
// ----------------------------------------------------------------------------
// agt6_pkg: shared types, constants and rounding helpers
// Link geometry, link weights, joint axis kinds, sine/cosine series divisors
// and the round-to-nearest helpers used by the gravity torque pipeline.
// ----------------------------------------------------------------------------
package agt6_pkg;

    localparam int NJ = 6;
    localparam int ANGLE_W_DEF = 16;
    localparam int TORQUE_W_DEF = 16;

    // sine/cosine unit latency in cycles, input to registered output
    localparam int SC_LAT = 22;

    typedef logic signed [31:0] t_q30;

    typedef enum logic [1:0] {
        AX_Z,
        AX_X,
        AX_NY
    } t_axis;

    typedef struct packed {
        logic [1:0] k;
        logic       aneg;
        logic       rneg;
    } t_sc_ctl;

    localparam longint QONE_L = 64'sd1 <<< 30;
    localparam longint E8 = 64'sd100000000;
    localparam longint E8H = 64'sd50000000;
    localparam t_q30 QONE = 32'sd1073741824;

    // pi/2 and pi/4 in Q30, quadrant thresholds and offsets
    localparam logic signed [33:0] HALF_PI = 34'sd1686629713;
    localparam logic signed [33:0] QTR_PI = 34'sd843314856;
    localparam logic signed [33:0] QUAD_TH1 = HALF_PI - QTR_PI;
    localparam logic signed [33:0] QUAD_TH2 = 2 * HALF_PI - QTR_PI;
    localparam logic signed [33:0] QUAD_TH3 = 3 * HALF_PI - QTR_PI;

    localparam t_axis JOINT_KIND [NJ] = '{AX_Z, AX_X, AX_X, AX_NY, AX_X, AX_NY};

    // series divisors and their 2^32 reciprocals
    localparam logic [7:0] SIN_DIV [NJ] = '{8'd6, 8'd20, 8'd42, 8'd72, 8'd110, 8'd156};
    localparam logic [7:0] COS_DIV [NJ] = '{8'd2, 8'd12, 8'd30, 8'd56, 8'd90, 8'd132};
    localparam logic [31:0] SIN_RCP [NJ] = '{
        32'((64'd1 << 32) / 64'd6),   32'((64'd1 << 32) / 64'd20),
        32'((64'd1 << 32) / 64'd42),  32'((64'd1 << 32) / 64'd72),
        32'((64'd1 << 32) / 64'd110), 32'((64'd1 << 32) / 64'd156)
    };
    localparam logic [31:0] COS_RCP [NJ] = '{
        32'((64'd1 << 32) / 64'd2),   32'((64'd1 << 32) / 64'd12),
        32'((64'd1 << 32) / 64'd30),  32'((64'd1 << 32) / 64'd56),
        32'((64'd1 << 32) / 64'd90),  32'((64'd1 << 32) / 64'd132)
    };

    // link offsets in Q30 metres
    localparam t_q30 LINK_OFF [NJ][3] = '{
        '{32'sd0, 32'sd0, 32'((64'sd6475000 * QONE_L + E8H) / E8)},
        '{32'((64'sd325000 * QONE_L + E8H) / E8), 32'sd0,
          32'((64'sd4575000 * QONE_L + E8H) / E8)},
        '{32'sd0, -32'((64'sd30000000 * QONE_L + E8H) / E8), 32'sd0},
        '{-32'((64'sd325000 * QONE_L + E8H) / E8),
          32'((64'sd21800000 * QONE_L + E8H) / E8),
          32'((64'sd6500000 * QONE_L + E8H) / E8)},
        '{-32'((64'sd275000 * QONE_L + E8H) / E8),
          32'((64'sd3600000 * QONE_L + E8H) / E8), 32'sd0},
        '{32'((64'sd275000 * QONE_L + E8H) / E8),
          32'((64'sd8200000 * QONE_L + E8H) / E8), 32'sd0}
    };

    // link centres of mass in Q30 metres, in the link frame
    localparam t_q30 LINK_COM [NJ][3] = '{
        '{32'((64'sd277280 * QONE_L + E8H) / E8), 32'sd0,
          32'((64'sd1793200 * QONE_L + E8H) / E8)},
        '{-32'((64'sd359140 * QONE_L + E8H) / E8),
          -32'((64'sd14996000 * QONE_L + E8H) / E8), 32'sd0},
        '{-32'((64'sd257000 * QONE_L + E8H) / E8),
          32'((64'sd9923000 * QONE_L + E8H) / E8),
          32'((64'sd5139700 * QONE_L + E8H) / E8)},
        '{32'((64'sd349840 * QONE_L + E8H) / E8),
          32'((64'sd2815300 * QONE_L + E8H) / E8), 32'sd0},
        '{-32'((64'sd68876 * QONE_L + E8H) / E8),
          32'((64'sd7638600 * QONE_L + E8H) / E8), 32'sd0},
        '{32'sd0, 32'((64'sd650000 * QONE_L + E8H) / E8), 32'sd0}
    };

    // link weights in Q20 newtons
    localparam t_q30 LINK_WT [NJ] = '{
        32'((64'sd13524 * (64'sd1 <<< 20) + 64'sd5000) / 64'sd10000),
        32'((64'sd135142 * (64'sd1 <<< 20) + 64'sd5000) / 64'sd10000),
        32'((64'sd71246 * (64'sd1 <<< 20) + 64'sd5000) / 64'sd10000),
        32'((64'sd36260 * (64'sd1 <<< 20) + 64'sd5000) / 64'sd10000),
        32'((64'sd38318 * (64'sd1 <<< 20) + 64'sd5000) / 64'sd10000),
        32'((64'sd17542 * (64'sd1 <<< 20) + 64'sd5000) / 64'sd10000)
    };

    // round Q60 to Q30, nearest, ties away from zero
    function automatic logic signed [35:0] rnd30(input logic signed [65:0] v);
        logic signed [65:0] t;
        t = v + (v[65] ? 66'sd536870911 : 66'sd536870912);
        return t[65:30];
    endfunction

    // round Q50 to Q10, nearest, ties away from zero
    function automatic logic signed [23:0] rnd40(input logic signed [63:0] v);
        logic signed [63:0] t;
        t = v + (v[63] ? 64'sd549755813887 : 64'sd549755813888);
        return t[63:40];
    endfunction

endpackage

FILE: hdl/arm_gravity_torque_6dof_core.sv
// ----------------------------------------------------------------------------
// arm_gravity_torque_6dof_core: gravity holding torques of a six-joint arm
// Pipelined forward kinematics, link weight moments and torque saturation.
// ----------------------------------------------------------------------------
// Usage:
//   Drive six joint angles (Q3.13 radians at the default width) and pulse
//   start. busy is high only while reset is held, so out of reset a beat is
//   taken on every cycle that start is high, one joint-angle set per cycle,
//   back to back.
//   Each beat gives one result beat, in which o_done is high for exactly
//   one cycle with o_torque_1..6 (1/1024 N*m) and o_saturated, set when
//   any torque was clipped to the output width.
//   A beat passes the angle register, the sine/cosine series (22 stages,
//   one term per three stages), the joint chain (two stages per joint,
//   each joint waiting on the frame of the one before) and seven stages
//   of lever, weight and torque sums. Results come out in input order.
//   The receiver cannot stall the block; a result not taken in its cycle is
//   gone. Synchronous reset drops every beat in flight; the first beat can
//   be accepted on the cycle after reset is released.
// ----------------------------------------------------------------------------
module arm_gravity_torque_6dof_core
    import agt6_pkg::*;
#(
    parameter int ANGLE_WIDTH  = ANGLE_W_DEF,
    parameter int TORQUE_WIDTH = TORQUE_W_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic signed [ANGLE_WIDTH-1:0]  i_joint_angle_1,
    input  logic signed [ANGLE_WIDTH-1:0]  i_joint_angle_2,
    input  logic signed [ANGLE_WIDTH-1:0]  i_joint_angle_3,
    input  logic signed [ANGLE_WIDTH-1:0]  i_joint_angle_4,
    input  logic signed [ANGLE_WIDTH-1:0]  i_joint_angle_5,
    input  logic signed [ANGLE_WIDTH-1:0]  i_joint_angle_6,
    output logic                           o_done,
    output logic signed [TORQUE_WIDTH-1:0] o_torque_1,
    output logic signed [TORQUE_WIDTH-1:0] o_torque_2,
    output logic signed [TORQUE_WIDTH-1:0] o_torque_3,
    output logic signed [TORQUE_WIDTH-1:0] o_torque_4,
    output logic signed [TORQUE_WIDTH-1:0] o_torque_5,
    output logic signed [TORQUE_WIDTH-1:0] o_torque_6,
    output logic                           o_saturated
);

    localparam int LAT = SC_LAT + 2 * NJ + 7;
    localparam int DLY = 2 * NJ - 2;
    localparam logic signed [32:0] T_MAX = 33'((64'sd1 <<< (TORQUE_WIDTH - 1)) - 64'sd1);
    localparam logic signed [32:0] T_MIN = -T_MAX - 33'sd1;

    logic [LAT:0] r_vld;

    logic signed [ANGLE_WIDTH-1:0] n_ang [NJ];
    logic signed [ANGLE_WIDTH-1:0] r_adly [0:DLY][NJ];
    t_q30 n_sin [NJ], n_cos [NJ];

    // joint chain: frame f is the world frame after joint f
    t_q30 r_frot [NJ][NJ][3][3];
    t_q30 r_fpos [NJ][NJ][3];
    t_q30 r_prot [NJ][NJ][3][3];
    t_q30 r_ppos [NJ][NJ][3];
    logic signed [63:0] r_pac [NJ][3], r_pbs [NJ][3], r_pas [NJ][3], r_pbc [NJ][3];
    logic signed [63:0] r_pd [NJ][3][3];
    t_q30 r_pkeep [NJ][3], r_pin [NJ][3];

    // centre of mass, lever and torque stages
    logic signed [63:0] r_cp [NJ][2][3];
    t_q30 r_cpos [NJ][2];
    t_q30 r_cax [NJ], r_cay [NJ], r_cjx [NJ], r_cjy [NJ];
    t_q30 r_w [NJ][2];
    t_q30 r_dax [NJ], r_day [NJ], r_djx [NJ], r_djy [NJ];
    logic signed [64:0] r_m1 [NJ][NJ], r_m2 [NJ][NJ];
    t_q30 r_lev [NJ][NJ];
    logic signed [63:0] r_lw [NJ][NJ];
    logic signed [63:0] n_acc [NJ], r_acc [NJ];
    logic signed [23:0] n_t [NJ];
    logic signed [32:0] n_te [NJ], n_tc [NJ];
    logic [NJ-1:0] n_ovf;
    logic signed [TORQUE_WIDTH-1:0] r_tq [NJ];
    logic r_sat;

    // hold off beats only while reset is held
    assign busy = ~i_rst_n;

    // track beats through the pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LAT-1:0], start};
        end
    end

    assign n_ang[0] = i_joint_angle_1;
    assign n_ang[1] = i_joint_angle_2;
    assign n_ang[2] = i_joint_angle_3;
    assign n_ang[3] = i_joint_angle_4;
    assign n_ang[4] = i_joint_angle_5;
    assign n_ang[5] = i_joint_angle_6;

    // skew the angles so each joint's sine arrives with its input frame
    always_ff @(posedge i_clk) begin
        r_adly[0] <= n_ang;
        for (int d = 1; d <= DLY; d++) begin
            r_adly[d] <= r_adly[d-1];
        end
    end

    for (genvar l = 0; l < NJ; l++) begin : g_lane
        agt6_sincos #(
            .ANGLE_WIDTH(ANGLE_WIDTH)
        ) u_sincos (
            .i_clk  (i_clk),
            .i_angle(r_adly[2*l][l]),
            .o_sin  (n_sin[l]),
            .o_cos  (n_cos[l])
        );
    end

    // joint chain, two stages per joint
    for (genvar s = 0; s < NJ; s++) begin : g_step
        localparam int CA = (JOINT_KIND[s] == AX_X) ? 1 : 0;
        localparam int CB = (JOINT_KIND[s] == AX_Z) ? 1 : 2;
        localparam int CK = (JOINT_KIND[s] == AX_Z) ? 2 : ((JOINT_KIND[s] == AX_X) ? 0 : 1);

        t_q30 n_rin [3][3];
        t_q30 n_pin [3];
        logic signed [35:0] n_na [3], n_nb [3], n_np [3];

        if (s == 0) begin : g_base
            always_comb begin
                for (int i = 0; i < 3; i++) begin
                    n_pin[i] = '0;
                    for (int j = 0; j < 3; j++) begin
                        n_rin[i][j] = (i == j) ? QONE : '0;
                    end
                end
            end
        end else begin : g_prev
            assign n_rin = r_frot[s-1][s-1];
            assign n_pin = r_fpos[s-1][s-1];
        end

        // form the rotation and offset products
        always_ff @(posedge i_clk) begin
            for (int i = 0; i < 3; i++) begin
                r_pac[s][i]   <= n_rin[i][CA] * n_cos[s];
                r_pbs[s][i]   <= n_rin[i][CB] * n_sin[s];
                r_pas[s][i]   <= n_rin[i][CA] * n_sin[s];
                r_pbc[s][i]   <= n_rin[i][CB] * n_cos[s];
                r_pkeep[s][i] <= n_rin[i][CK];
                r_pin[s][i]   <= n_pin[i];
                for (int k = 0; k < 3; k++) begin
                    r_pd[s][i][k] <= n_rin[i][k] * LINK_OFF[s][k];
                end
            end
        end

        always_comb begin
            for (int i = 0; i < 3; i++) begin
                n_na[i] = rnd30(r_pac[s][i] + r_pbs[s][i]);
                n_nb[i] = rnd30(r_pbc[s][i] - r_pas[s][i]);
                n_np[i] = rnd30(r_pd[s][i][0] + r_pd[s][i][1] + r_pd[s][i][2]);
            end
        end

        // round into the new frame and carry earlier frames along
        always_ff @(posedge i_clk) begin
            for (int f = 0; f < s; f++) begin
                r_prot[s][f] <= r_frot[s-1][f];
                r_ppos[s][f] <= r_fpos[s-1][f];
                r_frot[s][f] <= r_prot[s][f];
                r_fpos[s][f] <= r_ppos[s][f];
            end
            for (int i = 0; i < 3; i++) begin
                r_frot[s][s][i][CA] <= n_na[i][31:0];
                r_frot[s][s][i][CB] <= n_nb[i][31:0];
                r_frot[s][s][i][CK] <= r_pkeep[s][i];
                r_fpos[s][s][i]     <= r_pin[s][i] + n_np[i][31:0];
            end
        end
    end

    // place centres of mass and pick joint axes
    always_ff @(posedge i_clk) begin
        for (int l = 0; l < NJ; l++) begin
            for (int i = 0; i < 2; i++) begin
                r_cpos[l][i] <= r_fpos[NJ-1][l][i];
                for (int k = 0; k < 3; k++) begin
                    r_cp[l][i][k] <= r_frot[NJ-1][l][i][k] * LINK_COM[l][k];
                end
            end
            r_cjx[l] <= r_fpos[NJ-1][l][0];
            r_cjy[l] <= r_fpos[NJ-1][l][1];
            case (JOINT_KIND[l])
                AX_Z: begin
                    r_cax[l] <= r_frot[NJ-1][l][0][2];
                    r_cay[l] <= r_frot[NJ-1][l][1][2];
                end
                AX_X: begin
                    r_cax[l] <= r_frot[NJ-1][l][0][0];
                    r_cay[l] <= r_frot[NJ-1][l][1][0];
                end
                default: begin
                    r_cax[l] <= -r_frot[NJ-1][l][0][1];
                    r_cay[l] <= -r_frot[NJ-1][l][1][1];
                end
            endcase
        end
    end

    for (genvar l = 0; l < NJ; l++) begin : g_com
        logic signed [35:0] n_wr [2];

        always_comb begin
            for (int i = 0; i < 2; i++) begin
                n_wr[i] = rnd30(r_cp[l][i][0] + r_cp[l][i][1] + r_cp[l][i][2]);
            end
        end

        always_ff @(posedge i_clk) begin
            for (int i = 0; i < 2; i++) begin
                r_w[l][i] <= r_cpos[l][i] + n_wr[i][31:0];
            end
            r_dax[l] <= r_cax[l];
            r_day[l] <= r_cay[l];
            r_djx[l] <= r_cjx[l];
            r_djy[l] <= r_cjy[l];
        end
    end

    // lever of each link about each joint at or before it
    for (genvar l = 0; l < NJ; l++) begin : g_link
        for (genvar j = 0; j <= l; j++) begin : g_joint
            logic signed [32:0] n_rx, n_ry;
            logic signed [35:0] n_lv;

            assign n_rx = 33'(r_w[l][0]) - 33'(r_djx[j]);
            assign n_ry = 33'(r_w[l][1]) - 33'(r_djy[j]);
            assign n_lv = rnd30(r_m1[l][j] - r_m2[l][j]);

            always_ff @(posedge i_clk) begin
                r_m1[l][j]  <= n_ry * r_dax[j];
                r_m2[l][j]  <= n_rx * r_day[j];
                r_lev[l][j] <= n_lv[31:0];
                r_lw[l][j]  <= r_lev[l][j] * LINK_WT[l];
            end
        end
    end

    // sum moments per joint
    always_comb begin
        for (int j = 0; j < NJ; j++) begin
            n_acc[j] = '0;
            for (int l = j; l < NJ; l++) begin
                n_acc[j] = n_acc[j] + r_lw[l][j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
    end

    // round to torque units and clip
    always_comb begin
        for (int j = 0; j < NJ; j++) begin
            n_t[j]  = rnd40(r_acc[j]);
            n_te[j] = 33'(n_t[j]);
            if (n_te[j] > T_MAX) begin
                n_tc[j]  = T_MAX;
                n_ovf[j] = 1'b1;
            end else if (n_te[j] < T_MIN) begin
                n_tc[j]  = T_MIN;
                n_ovf[j] = 1'b1;
            end else begin
                n_tc[j]  = n_te[j];
                n_ovf[j] = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < NJ; j++) begin
            r_tq[j] <= n_tc[j][TORQUE_WIDTH-1:0];
        end
        r_sat <= |n_ovf;
    end

    assign o_done      = r_vld[LAT];
    assign o_torque_1  = r_tq[0];
    assign o_torque_2  = r_tq[1];
    assign o_torque_3  = r_tq[2];
    assign o_torque_4  = r_tq[3];
    assign o_torque_5  = r_tq[4];
    assign o_torque_6  = r_tq[5];
    assign o_saturated = r_sat;

endmodule

FILE: hdl/agt6_sincos.sv
// ----------------------------------------------------------------------------
// agt6_sincos: pipelined sine and cosine of one joint angle
// Quadrant reduction, then a six-term Taylor series with one term per three
// stages (square, round and reciprocal multiply, divide correction).
// ----------------------------------------------------------------------------
module agt6_sincos
    import agt6_pkg::*;
#(
    parameter int ANGLE_WIDTH = ANGLE_W_DEF
) (
    input  logic                          i_clk,
    input  logic signed [ANGLE_WIDTH-1:0] i_angle,
    output t_q30                          o_sin,
    output t_q30                          o_cos
);

    // reduction stage
    logic signed [33:0] n_a, n_m, n_r;
    logic [1:0]         n_k;
    t_sc_ctl            r_ctl1, r_ctl2;
    logic [29:0]        r_rm1, r_rm2;
    logic [59:0]        r_rsq;
    logic [60:0]        n_x2s;

    // series stages
    logic [30:0] r_ts [0:NJ], r_tc [0:NJ], r_x2 [0:NJ];
    t_q30        r_ss [0:NJ], r_sc [0:NJ];
    t_sc_ctl     r_ctl [0:NJ];

    logic [60:0] r_aps [NJ], r_apc [NJ];
    logic [30:0] r_ax2 [NJ];
    t_q30        r_ass [NJ], r_asc [NJ];
    t_sc_ctl     r_actl [NJ];

    logic [30:0] r_bts [NJ], r_btc [NJ], r_bx2 [NJ];
    logic [62:0] r_bms [NJ], r_bmc [NJ];
    t_q30        r_bss [NJ], r_bsc [NJ];
    t_sc_ctl     r_bctl [NJ];

    t_q30 n_s0, n_s1, n_c1, r_sin, r_cos;

    // scale to Q30 and find the quadrant
    always_comb begin
        n_a = 34'(i_angle) <<< (33 - ANGLE_WIDTH);
        n_m = n_a[33] ? -n_a : n_a;
        if (n_m >= QUAD_TH3) begin
            n_k = 2'd3;
        end else if (n_m >= QUAD_TH2) begin
            n_k = 2'd2;
        end else if (n_m >= QUAD_TH1) begin
            n_k = 2'd1;
        end else begin
            n_k = 2'd0;
        end
        case (n_k)
            2'd0:    n_r = n_m;
            2'd1:    n_r = n_m - HALF_PI;
            2'd2:    n_r = n_m - 2 * HALF_PI;
            default: n_r = n_m - 3 * HALF_PI;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_ctl1 <= '{k: n_k, aneg: n_a[33], rneg: n_r[33]};
        r_rm1  <= n_r[33] ? 30'(-n_r) : n_r[29:0];
        r_ctl2 <= r_ctl1;
        r_rm2  <= r_rm1;
        r_rsq  <= r_rm1 * r_rm1;
    end

    // round the square and seed the series
    assign n_x2s = 61'(r_rsq) + 61'd536870912;

    always_ff @(posedge i_clk) begin
        r_x2[0]  <= n_x2s[60:30];
        r_ts[0]  <= 31'(r_rm2);
        r_tc[0]  <= 31'(QONE);
        r_ss[0]  <= 32'(r_rm2);
        r_sc[0]  <= QONE;
        r_ctl[0] <= r_ctl2;
    end

    // one series term per three stages
    for (genvar it = 0; it < NJ; it++) begin : g_term
        logic [61:0] n_bs, n_bc;
        logic [30:0] n_trs, n_trc, n_q0s, n_q0c, n_qs, n_qc;
        logic [39:0] n_rs, n_rc;

        always_ff @(posedge i_clk) begin
            r_aps[it]  <= r_ts[it] * r_x2[it];
            r_apc[it]  <= r_tc[it] * r_x2[it];
            r_ax2[it]  <= r_x2[it];
            r_ass[it]  <= r_ss[it];
            r_asc[it]  <= r_sc[it];
            r_actl[it] <= r_ctl[it];
        end

        always_comb begin
            n_bs  = 62'(r_aps[it]) + 62'd536870912;
            n_bc  = 62'(r_apc[it]) + 62'd536870912;
            n_trs = n_bs[60:30];
            n_trc = n_bc[60:30];
        end

        always_ff @(posedge i_clk) begin
            r_bts[it]  <= n_trs;
            r_btc[it]  <= n_trc;
            r_bms[it]  <= n_trs * SIN_RCP[it];
            r_bmc[it]  <= n_trc * COS_RCP[it];
            r_bx2[it]  <= r_ax2[it];
            r_bss[it]  <= r_ass[it];
            r_bsc[it]  <= r_asc[it];
            r_bctl[it] <= r_actl[it];
        end

        // fix the reciprocal quotient by at most one
        always_comb begin
            n_q0s = r_bms[it][62:32];
            n_q0c = r_bmc[it][62:32];
            n_rs  = 40'(r_bts[it]) - 40'(n_q0s) * 40'(SIN_DIV[it]);
            n_rc  = 40'(r_btc[it]) - 40'(n_q0c) * 40'(COS_DIV[it]);
            n_qs  = n_q0s + 31'(n_rs >= 40'(SIN_DIV[it]));
            n_qc  = n_q0c + 31'(n_rc >= 40'(COS_DIV[it]));
        end

        always_ff @(posedge i_clk) begin
            r_ts[it+1]  <= n_qs;
            r_tc[it+1]  <= n_qc;
            r_x2[it+1]  <= r_bx2[it];
            r_ctl[it+1] <= r_bctl[it];
            if ((it % 2) == 0) begin
                r_ss[it+1] <= r_bss[it] - $signed({1'b0, n_qs});
                r_sc[it+1] <= r_bsc[it] - $signed({1'b0, n_qc});
            end else begin
                r_ss[it+1] <= r_bss[it] + $signed({1'b0, n_qs});
                r_sc[it+1] <= r_bsc[it] + $signed({1'b0, n_qc});
            end
        end
    end

    // restore quadrant and sign
    always_comb begin
        n_s0 = r_ctl[NJ].rneg ? -r_ss[NJ] : r_ss[NJ];
        case (r_ctl[NJ].k)
            2'd0: begin
                n_s1 = n_s0;
                n_c1 = r_sc[NJ];
            end
            2'd1: begin
                n_s1 = r_sc[NJ];
                n_c1 = -n_s0;
            end
            2'd2: begin
                n_s1 = -n_s0;
                n_c1 = -r_sc[NJ];
            end
            default: begin
                n_s1 = -r_sc[NJ];
                n_c1 = n_s0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_sin <= r_ctl[NJ].aneg ? -n_s1 : n_s1;
        r_cos <= n_c1;
    end

    assign o_sin = r_sin;
    assign o_cos = r_cos;

endmodule

FILE: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: gravity torque core testbench
// Drives joint-angle beats with random gaps (none in the back-to-back test),
// predicts the six holding torques and clip flag with a fixed-point model and
// compares each result beat in order against a ring of predicted torque sets.
// ----------------------------------------------------------------------------
module tb_top
    import agt6_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int AW = 16;
    localparam int TW = 16;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RING_N = 64;

    typedef struct {
        logic signed [TW-1:0] trq [NJ];
        logic                 sat;
    } t_torque_set;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic signed [AW-1:0] ang [NJ] = '{default: '0};
    logic                 o_done;
    logic signed [TW-1:0] o_trq [NJ];
    logic                 o_saturated;

    // predictions in flight, written at wr and read at rd
    t_torque_set exp_ring [RING_N];
    int          exp_wr = 0;
    int          exp_rd = 0;
    int          fail_cnt = 0;
    int          cycle_cnt = 0;
    bit          gaps_on = 1'b1;

    arm_gravity_torque_6dof_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_joint_angle_1(ang[0]), .i_joint_angle_2(ang[1]),
        .i_joint_angle_3(ang[2]), .i_joint_angle_4(ang[3]),
        .i_joint_angle_5(ang[4]), .i_joint_angle_6(ang[5]),
        .o_done(o_done),
        .o_torque_1(o_trq[0]), .o_torque_2(o_trq[1]), .o_torque_3(o_trq[2]),
        .o_torque_4(o_trq[3]), .o_torque_5(o_trq[4]), .o_torque_6(o_trq[5]),
        .o_saturated(o_saturated)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Round to nearest, ties away from zero
    function automatic longint rshift(longint v, int sh);
        longint m;
        m = (v < 0) ? -v : v;
        m = (m + (64'sd1 <<< (sh - 1))) >>> sh;
        return (v < 0) ? -m : m;
    endfunction

    function automatic void sin_cos(longint a, output longint sn, output longint cs);
        longint m, k, r, rm, x2, ts, ss, tc, sc, s0, s1, c1;
        m = (a < 0) ? -a : a;
        k = (m + longint'(QTR_PI)) / longint'(HALF_PI);
        r = m - k * longint'(HALF_PI);
        rm = (r < 0) ? -r : r;
        x2 = rshift(rm * rm, 30);
        ts = rm; ss = rm; tc = QONE_L; sc = QONE_L;
        for (int i = 1; i <= 6; i++) begin
            ts = rshift(ts * x2, 30) / longint'((2 * i) * (2 * i + 1));
            tc = rshift(tc * x2, 30) / longint'((2 * i - 1) * (2 * i));
            if (i & 1) begin
                ss -= ts; sc -= tc;
            end else begin
                ss += ts; sc += tc;
            end
        end
        s0 = (r < 0) ? -ss : ss;
        case (k & 3)
            0: begin s1 = s0; c1 = sc; end
            1: begin s1 = sc; c1 = -s0; end
            2: begin s1 = -s0; c1 = -sc; end
            default: begin s1 = -sc; c1 = s0; end
        endcase
        sn = (a < 0) ? -s1 : s1;
        cs = c1;
    endfunction

    // Predict the holding torques of one joint-angle set
    function automatic t_torque_set predict_torques(logic signed [AW-1:0] a [NJ]);
        t_torque_set res;
        longint rot [NJ+1][3][3];
        longint pos [NJ+1][3];
        longint lr [3][3];
        longint acc [NJ];
        longint w [2];
        longint sn, cs, sp, sm, rx, ry, ax, ay, lev, t;
        res.sat = 1'b0;
        for (int i = 0; i < 3; i++) begin
            pos[0][i] = 0;
            for (int j = 0; j < 3; j++) rot[0][i][j] = (i == j) ? QONE_L : 0;
        end
        for (int l = 0; l < NJ; l++) begin
            sin_cos(longint'(a[l]) * (64'sd1 <<< (33 - AW)), sn, cs);
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++) lr[i][j] = 0;
            case (JOINT_KIND[l])
                AX_Z: begin
                    lr[0][0] = cs; lr[0][1] = -sn; lr[1][0] = sn; lr[1][1] = cs;
                    lr[2][2] = QONE_L;
                end
                AX_X: begin
                    lr[0][0] = QONE_L; lr[1][1] = cs; lr[1][2] = -sn; lr[2][1] = sn;
                    lr[2][2] = cs;
                end
                default: begin
                    lr[0][0] = cs; lr[0][2] = -sn; lr[1][1] = QONE_L; lr[2][0] = sn;
                    lr[2][2] = cs;
                end
            endcase
            for (int i = 0; i < 3; i++) begin
                sp = 0;
                for (int k = 0; k < 3; k++) sp += rot[l][i][k] * longint'(LINK_OFF[l][k]);
                pos[l+1][i] = pos[l][i] + rshift(sp, 30);
                for (int j = 0; j < 3; j++) begin
                    sm = 0;
                    for (int k = 0; k < 3; k++) sm += rot[l][i][k] * lr[k][j];
                    rot[l+1][i][j] = rshift(sm, 30);
                end
            end
            acc[l] = 0;
        end
        for (int l = 0; l < NJ; l++) begin
            for (int i = 0; i < 2; i++) begin
                sp = 0;
                for (int k = 0; k < 3; k++) sp += rot[l+1][i][k] * longint'(LINK_COM[l][k]);
                w[i] = pos[l+1][i] + rshift(sp, 30);
            end
            for (int j = 0; j <= l; j++) begin
                rx = w[0] - pos[j+1][0];
                ry = w[1] - pos[j+1][1];
                case (JOINT_KIND[j])
                    AX_Z: begin ax = rot[j+1][0][2]; ay = rot[j+1][1][2]; end
                    AX_X: begin ax = rot[j+1][0][0]; ay = rot[j+1][1][0]; end
                    default: begin ax = -rot[j+1][0][1]; ay = -rot[j+1][1][1]; end
                endcase
                lev = rshift(ry * ax - rx * ay, 30);
                acc[j] += lev * longint'(LINK_WT[l]);
            end
        end
        for (int j = 0; j < NJ; j++) begin
            t = rshift(acc[j], 40);
            if (t > 32767) begin t = 32767; res.sat = 1'b1; end
            if (t < -32768) begin t = -32768; res.sat = 1'b1; end
            res.trq[j] = t[TW-1:0];
        end
        return res;
    endfunction

    // Send one beat, with a random gap ahead of it
    task automatic send_angles(logic signed [AW-1:0] a [NJ]);
        int gap;
        gap = (gaps_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 17) : 0;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        for (int i = 0; i < NJ; i++) ang[i] <= a[i];
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        exp_ring[exp_wr % RING_N] = predict_torques(a);
        exp_wr++;
    endtask

    task automatic send_random(int n, int mode);
        logic signed [AW-1:0] a [NJ];
        for (int c = 0; c < n; c++) begin
            for (int i = 0; i < NJ; i++) begin
                case (mode)
                    0: a[i] = 16'($urandom);
                    1: a[i] = $urandom_range(0, 2) == 0 ? 16'sh8000 :
                              ($urandom_range(0, 1) ? 16'sh7fff :
                               16'(int'($urandom_range(0, 24)) * 3217 - 38604));
                    default: a[i] = 16'(int'($urandom_range(0, 25736)) - 12868);
                endcase
            end
            send_angles(a);
        end
    endtask

    // Directed: zero, extremes, quadrant boundaries, one joint at a time, mixed pose
    task automatic test_directed();
        logic signed [AW-1:0] a [NJ];
        logic signed [AW-1:0] vals [10] = '{16'sh0000, 16'sh7fff, 16'sh8000, 16'sh0001,
            16'shffff, 16'sd3217, -16'sd3217, 16'sd12868, 16'sd25736, -16'sd25736};
        for (int v = 0; v < 10; v++) begin
            for (int i = 0; i < NJ; i++) a[i] = vals[v];
            send_angles(a);
        end
        for (int i = 0; i < NJ; i++) begin
            foreach (a[j]) a[j] = 16'sh0000;
            a[i] = 16'sd12868;
            send_angles(a);
            a[i] = 16'sh8000;
            send_angles(a);
        end
        foreach (a[j]) a[j] = 16'(j[0] ? 16'sh5555 : 16'shaaaa);
        send_angles(a);
    endtask

    task automatic test_random_full();
        send_random(900, 0);
    endtask

    task automatic test_random_corners();
        send_random(400, 1);
    endtask

    task automatic test_random_back_to_back();
        gaps_on = 1'b0;
        send_random(450, 2);
    endtask

    // Compare each result beat against the oldest prediction
    always @(posedge i_clk) begin
        t_torque_set exp_set;
        cycle_cnt <= cycle_cnt + 1;
        if (i_rst_n && o_done) begin
            if (exp_rd == exp_wr) begin
                $display("%0t: result beat with nothing expected", $time);
                fail_cnt++;
            end else begin
                exp_set = exp_ring[exp_rd % RING_N];
                exp_rd++;
                for (int j = 0; j < NJ; j++)
                    if (o_trq[j] !== exp_set.trq[j]) begin
                        $display("%0t: torque_%0d expected %0d actual %0d", $time, j + 1,
                                 exp_set.trq[j], o_trq[j]);
                        fail_cnt++;
                    end
                if (o_saturated !== exp_set.sat) begin
                    $display("%0t: saturated expected %0b actual %0b", $time,
                             exp_set.sat, o_saturated);
                    fail_cnt++;
                end
            end
        end
    end

    // Bound the run
    always @(posedge i_clk) begin
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("arm_gravity_torque_6dof_core test failed");
            $finish;
        end
    end

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random_full();
        test_random_corners();
        test_random_back_to_back();
        start <= 1'b0;
        while (exp_rd != exp_wr) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (fail_cnt == 0 && exp_rd == exp_wr) begin
            $display("arm_gravity_torque_6dof_core test passed");
        end else begin
            $display("arm_gravity_torque_6dof_core test failed");
        end
        $finish;
    end
endmodule
